// ===== rtl/core/rae_pkg.sv =====
// ----------------------------------------------------------------------------
// rae_pkg
// Shared widths, opcodes, status codes and types of the register ALU
// instruction executor.
// ----------------------------------------------------------------------------
package rae_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int REGISTER_COUNT = 8;
  localparam int IDX_W          = $clog2(REGISTER_COUNT);
  localparam int OPCODE_W       = 6;
  localparam int INSTR_W        = 16;
  localparam int STATUS_W       = 2;
  localparam int CNT_W          = $clog2(DATA_WIDTH + 1);
  localparam int OUT_W          = IDX_W + DATA_WIDTH + STATUS_W;
  localparam int OUT_TDATA_W    = ((OUT_W + 7) / 8) * 8;

  localparam int OPCODE_LSB = 9;
  localparam int DEST_LSB   = 6;
  localparam int SRC1_LSB   = 3;
  localparam int SRC2_LSB   = 0;

  localparam logic [OPCODE_W-1:0] OP_ADD = OPCODE_W'(0);
  localparam logic [OPCODE_W-1:0] OP_SUB = OPCODE_W'(1);
  localparam logic [OPCODE_W-1:0] OP_MUL = OPCODE_W'(2);
  localparam logic [OPCODE_W-1:0] OP_DIV = OPCODE_W'(3);

  localparam logic [STATUS_W-1:0] STATUS_WRITTEN  = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = STATUS_W'(2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      addr;
    logic [DATA_WIDTH-1:0] data;
  } rf_wr_t;

endpackage

// ===== rtl/core/register_alu_instruction_executor_unit.sv =====
// ----------------------------------------------------------------------------
// register_alu_instruction_executor_unit
// Executes one three-register ALU instruction per item on an eight-entry
// register file and reports destination, written value and status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one 16-bit instruction word per item.
//   Output channel m_*: one result item per instruction, in order.
//   An instruction is taken only while the unit is idle. For add, subtract,
//   multiply, divides by zero and rejected opcodes the result passes through
//   the read and done states into the output register; a divide with a nonzero
//   divisor also waits in the divide state for the one-bit-per-cycle divider.
//   The next instruction may be accepted in the cycle after the result is
//   loaded into the output register.
//   Source registers are read from the register file RAMs at acceptance,
//   through their registered read ports; the destination is written when the
//   result is loaded, so a following instruction always sees the new value.
//   Reset empties the output register and returns every register to its
//   own index, with no clearing pass.
//   While the receiver stalls, the result is held in the output register;
//   a finished result behind it waits in the unit until the slot frees.
// ----------------------------------------------------------------------------
module register_alu_instruction_executor_unit
  import rae_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [INSTR_W-1:0]     s_tdata,  // instruction
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // dest_index, write_value, status, zero pad
);

  state_t                state;
  state_t                state_next;
  logic                  accept;
  logic                  out_free;
  logic [OPCODE_W-1:0]   op;
  logic [IDX_W-1:0]      dest;
  logic [DATA_WIDTH-1:0] src_a;
  logic [DATA_WIDTH-1:0] src_b;
  logic [2*DATA_WIDTH-1:0] product;
  logic [DATA_WIDTH-1:0] res_value;
  logic [DATA_WIDTH-1:0] res_value_next;
  logic [STATUS_W-1:0]   res_status;
  logic [STATUS_W-1:0]   res_status_next;
  logic                  div_start;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_quotient;
  logic                  load_out;
  rf_wr_t                rf_wr;
  logic [IDX_W-1:0]      out_dest;
  logic [DATA_WIDTH-1:0] out_value;
  logic [STATUS_W-1:0]   out_status;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign product  = src_a * src_b;

  rae_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_addr_a (s_tdata[SRC1_LSB +: IDX_W]),
    .rd_addr_b (s_tdata[SRC2_LSB +: IDX_W]),
    .rd_data_a (src_a),
    .rd_data_b (src_b),
    .wr        (rf_wr)
  );

  rae_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (src_a),
    .divisor  (src_b),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_READ;
      S_READ: state_next = div_start ? S_DIV : S_DONE;
      S_DIV:  if (div_done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      S_IDLE: s_tready = 1'b1;
      S_READ: div_start = (op == OP_DIV) && (src_b != '0);
      S_DIV:  ;
      S_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    rf_wr.en   = load_out && (res_status == STATUS_WRITTEN);
    rf_wr.addr = dest;
    rf_wr.data = res_value;
  end

  always_comb begin
    res_status_next = STATUS_WRITTEN;
    res_value_next  = '0;
    unique case (op)
      OP_ADD: res_value_next = src_a + src_b;
      OP_SUB: res_value_next = src_a - src_b;
      OP_MUL: res_value_next = product[DATA_WIDTH-1:0];
      OP_DIV: if (src_b == '0) res_status_next = STATUS_DIV_ZERO;
      default: res_status_next = STATUS_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= s_tdata[OPCODE_LSB +: OPCODE_W];
      dest <= s_tdata[DEST_LSB +: IDX_W];
    end
    if (state == S_READ) begin
      res_status <= res_status_next;
      res_value  <= res_value_next;
    end else if (state == S_DIV && div_done) begin
      res_value <= div_quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dest   <= dest;
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - OUT_W)'(0), out_status, out_value, out_dest};

`ifndef SYNTHESIS
  a_write_matches_out: assert property (@(posedge clk) disable iff (rst)
    rf_wr.en |=> m_tvalid && out_status == STATUS_WRITTEN &&
                 out_value == $past(rf_wr.data) && out_dest == $past(rf_wr.addr))
    else $error("register write differs from reported result");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status != STATUS_WRITTEN |-> out_value == '0)
    else $error("rejected instruction reports nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_status == STATUS_WRITTEN || out_status == STATUS_UNKNOWN ||
                 out_status == STATUS_DIV_ZERO)
    else $error("undefined status code");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");
`endif

endmodule

// ===== rtl/core/rae_ram.sv =====
// ----------------------------------------------------------------------------
// rae_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rae_regfile.sv =====
// ----------------------------------------------------------------------------
// rae_regfile
// Register file: two RAM copies for two read ports, with per-entry valid
// bits that return the reset contents until an entry is first written.
// ----------------------------------------------------------------------------
module rae_regfile
  import rae_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_W-1:0]      rd_addr_a,
  input  logic [IDX_W-1:0]      rd_addr_b,
  output logic [DATA_WIDTH-1:0] rd_data_a,
  output logic [DATA_WIDTH-1:0] rd_data_b,
  input  rf_wr_t                wr
);

  logic [REGISTER_COUNT-1:0] valid;
  logic [IDX_W-1:0]          addr_a_q;
  logic [IDX_W-1:0]          addr_b_q;
  logic                      valid_a_q;
  logic                      valid_b_q;
  logic [DATA_WIDTH-1:0]     ram_a;
  logic [DATA_WIDTH-1:0]     ram_b;

  rae_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REGISTER_COUNT)) u_ram_a (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr_a),
    .rdata (ram_a)
  );

  rae_ram #(.WIDTH(DATA_WIDTH), .DEPTH(REGISTER_COUNT)) u_ram_b (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr_b),
    .rdata (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    addr_a_q  <= rd_addr_a;
    addr_b_q  <= rd_addr_b;
    valid_a_q <= valid[rd_addr_a];
    valid_b_q <= valid[rd_addr_b];
  end

  assign rd_data_a = valid_a_q ? ram_a : DATA_WIDTH'(addr_a_q);
  assign rd_data_b = valid_b_q ? ram_b : DATA_WIDTH'(addr_b_q);

endmodule

// ===== rtl/core/rae_div.sv =====
// ----------------------------------------------------------------------------
// rae_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rae_div
  import rae_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient
);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] dvs;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   diff;

  assign shifted = {rem, quotient[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= CNT_W'(DATA_WIDTH);
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (!diff[DATA_WIDTH]) begin
        rem      <= diff[DATA_WIDTH-1:0];
        quotient <= {quotient[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem      <= shifted[DATA_WIDTH-1:0];
        quotient <= {quotient[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== test/tb_register_alu_instruction_executor_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_register_alu_instruction_executor_unit
// Streams instruction words into the executor and keeps a shadow register
// file that predicts each result item. Every item leaving the unit is
// compared field by field against the oldest prediction. The run covers
// directed corner cases, random traffic under several idle and stall mixes,
// and one long output hold that backs the unit up.
// ----------------------------------------------------------------------------
module tb_register_alu_instruction_executor_unit;
  import rae_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 500;

  localparam logic [OPCODE_W-1:0] OP_FIRST_UNKNOWN = OP_DIV + 1'b1;
  localparam logic [OPCODE_W-1:0] OP_LAST_UNKNOWN  = '1;

  typedef struct {
    logic [IDX_W-1:0]      dest;
    logic [DATA_WIDTH-1:0] value;
    logic [STATUS_W-1:0]   status;
  } alu_result_t;

  class alu_shadow;
    logic [DATA_WIDTH-1:0] regs [REGISTER_COUNT];
    alu_result_t           pending[$];
    int                    mismatches;
    int                    checked;
    int                    written;
    int                    unknown;
    int                    div_zero;

    function new();
      for (int i = 0; i < REGISTER_COUNT; i++) regs[i] = DATA_WIDTH'(i);
      mismatches = 0;
      checked    = 0;
      written    = 0;
      unknown    = 0;
      div_zero   = 0;
    endfunction

    function void execute(logic [INSTR_W-1:0] word);
      logic [OPCODE_W-1:0]   opcode;
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      alu_result_t           res;
      opcode     = word[OPCODE_LSB +: OPCODE_W];
      res.dest   = word[DEST_LSB +: IDX_W];
      a          = regs[word[SRC1_LSB +: IDX_W]];
      b          = regs[word[SRC2_LSB +: IDX_W]];
      res.value  = '0;
      res.status = STATUS_WRITTEN;
      case (opcode)
        OP_ADD: res.value = a + b;
        OP_SUB: res.value = a - b;
        OP_MUL: res.value = a * b;
        OP_DIV: begin
          if (b == '0) res.status = STATUS_DIV_ZERO;
          else res.value = a / b;
        end
        default: res.status = STATUS_UNKNOWN;
      endcase
      case (res.status)
        STATUS_WRITTEN: begin
          regs[res.dest] = res.value;
          written++;
        end
        STATUS_UNKNOWN: unknown++;
        default: div_zero++;
      endcase
      pending.push_back(res);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
    endfunction

    function void compare_result(logic [OUT_TDATA_W-1:0] tdata);
      alu_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result item with none pending, expected nothing, got %h",
                 $time, tdata);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (tdata[IDX_W-1:0] !== want.dest)
        report("dest_index", want.dest, tdata[IDX_W-1:0]);
      if (tdata[IDX_W +: DATA_WIDTH] !== want.value)
        report("write_value", want.value, tdata[IDX_W +: DATA_WIDTH]);
      if (tdata[IDX_W+DATA_WIDTH +: STATUS_W] !== want.status)
        report("status", want.status, tdata[IDX_W+DATA_WIDTH +: STATUS_W]);
      if (tdata[OUT_TDATA_W-1:OUT_W] !== '0)
        report("pad", '0, tdata[OUT_TDATA_W-1:OUT_W]);
    endfunction
  endclass

  logic                   clk;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [INSTR_W-1:0]     s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  alu_shadow shadow;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  bit        hold_req       = 1'b0;
  int        hold_left      = 0;
  int        quiet_cycles   = 0;

  register_alu_instruction_executor_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hold off the output for a long stretch on request, else stall at random
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) shadow.execute(s_tdata);
      if (m_tvalid && m_tready) shadow.compare_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL register_alu_instruction_executor_unit");
        $finish;
      end
    end
  end

  function automatic logic [INSTR_W-1:0] make_instr(logic fmt, logic [OPCODE_W-1:0] opcode,
                                                     logic [IDX_W-1:0] dest,
                                                     logic [IDX_W-1:0] src1,
                                                     logic [IDX_W-1:0] src2);
    logic [INSTR_W-1:0] word;
    word                         = '0;
    word[INSTR_W-1]              = fmt;
    word[OPCODE_LSB +: OPCODE_W] = opcode;
    word[DEST_LSB +: IDX_W]      = dest;
    word[SRC1_LSB +: IDX_W]      = src1;
    word[SRC2_LSB +: IDX_W]      = src2;
    return word;
  endfunction

  function automatic logic [INSTR_W-1:0] random_instr();
    logic [OPCODE_W-1:0] opcode;
    if ($urandom_range(99) < 8)
      opcode = OPCODE_W'($urandom_range(OP_LAST_UNKNOWN, OP_FIRST_UNKNOWN));
    else
      opcode = OPCODE_W'($urandom_range(OP_DIV, OP_ADD));
    return make_instr(1'($urandom), opcode, IDX_W'($urandom), IDX_W'($urandom),
                      IDX_W'($urandom));
  endfunction

  task automatic send_instruction(logic [INSTR_W-1:0] word);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_instruction(random_instr());
  endtask

  initial begin
    logic [INSTR_W-1:0] directed[$];
    shadow = new();
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    directed.push_back(make_instr(1'b0, OP_ADD, 0, 0, 0));
    directed.push_back(make_instr(1'b0, OP_SUB, 0, 0, 1));
    directed.push_back(make_instr(1'b0, OP_ADD, 2, 0, 0));
    directed.push_back(make_instr(1'b0, OP_MUL, 3, 0, 0));
    directed.push_back(make_instr(1'b0, OP_MUL, 4, 0, 2));
    directed.push_back(make_instr(1'b0, OP_DIV, 5, 0, 7));
    directed.push_back(make_instr(1'b0, OP_DIV, 6, 0, 3));
    directed.push_back(make_instr(1'b1, OP_DIV, 1, 1, 0));
    directed.push_back(make_instr(1'b0, OP_DIV, 5, 0, 1));
    directed.push_back(make_instr(1'b0, OP_DIV, 7, 1, 1));
    directed.push_back(make_instr(1'b0, OP_ADD, 7, 5, 1));
    directed.push_back(make_instr(1'b0, OP_FIRST_UNKNOWN, 6, 0, 0));
    directed.push_back(make_instr(1'b1, OP_LAST_UNKNOWN, 7, 7, 7));
    directed.push_back(make_instr(1'b0, OP_SUB, 6, 6, 6));
    directed.push_back(make_instr(1'b0, OP_ADD, 0, 0, 0));
    directed.push_back(make_instr(1'b0, OP_MUL, 2, 2, 5));
    directed.push_back(make_instr(1'b0, OP_DIV, 3, 3, 0));
    directed.push_back(make_instr(1'b0, OP_DIV, 4, 4, 4));
    directed.push_back(make_instr(1'b1, OP_SUB, 1, 1, 0));
    directed.push_back(make_instr(1'b0, OP_MUL, 5, 0, 0));
    directed.push_back(make_instr(1'b1, OPCODE_W'(42), 3, 5, 2));
    foreach (directed[i]) send_instruction(directed[i]);

    // back up the unit behind a long output hold
    hold_req = 1'b1;
    run_phase(PHASE_ITEMS, 0, 0);
    run_phase(PHASE_ITEMS, 85, 0);
    run_phase(PHASE_ITEMS, 0, 85);
    run_phase(PHASE_ITEMS, 31, 31);
    @(negedge clk) s_tvalid <= 1'b0;

    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d instructions: %0d writes, %0d unknown opcodes, %0d divides by zero",
             shadow.checked, shadow.written, shadow.unknown, shadow.div_zero);
    $display("Traffic mixes: free flow, sparse input, heavy output stall, both, long hold");
    if (shadow.mismatches == 0 && shadow.pending.size() == 0) begin
      $display("PASS register_alu_instruction_executor_unit");
    end else begin
      $display("FAIL register_alu_instruction_executor_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rae_pkg.sv
rtl/core/rae_ram.sv
rtl/core/rae_regfile.sv
rtl/core/rae_div.sv
rtl/core/register_alu_instruction_executor_unit.sv
test/tb_register_alu_instruction_executor_unit.sv
